### rtl/bu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bu_pkg: shared constants and types of the bilinear upsampler
// Sizes of the stored plane, field widths, fixed-point format and the
// control word that the sequencer sends to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package bu_pkg;

  // plane limits
  localparam int MAX_HEIGHT   = 64;
  localparam int MAX_WIDTH    = 64;
  localparam int MAX_CHANNELS = 4;
  localparam int MAX_FACTOR   = 8;
  localparam int FRAC_BITS    = 12;

  // field widths
  localparam int OP_W     = 1;
  localparam int CH_W     = 2;
  localparam int COORD_W  = 9;
  localparam int SAMPLE_W = 16;
  localparam int DIM_W    = 7;
  localparam int FAC_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // derived widths
  localparam int IDX_W     = $clog2(MAX_HEIGHT);          // row / column index
  localparam int CH_ADDR_W = $clog2(MAX_CHANNELS);
  localparam int ADDR_W    = CH_ADDR_W + 2 * IDX_W;
  localparam int DEPTH     = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int ODIM_W    = $clog2(MAX_HEIGHT * MAX_FACTOR) + 1;  // output size
  localparam int DEN_W     = ODIM_W - 1;                  // output size - 1
  localparam int NUM_W     = IDX_W + COORD_W;             // (in-1) * coord
  localparam int QUOT_W    = IDX_W + FRAC_BITS;           // index . fraction
  localparam int WGT_W     = FRAC_BITS + 1;               // 0 .. ONE
  localparam int PROD_W    = 2 * FRAC_BITS + 1;           // weight product
  localparam int TERM_W    = PROD_W + SAMPLE_W;
  localparam int ACC_W     = TERM_W + 1;
  localparam int STEP_W    = $clog2(QUOT_W + 1);

  localparam logic [WGT_W-1:0] ONE = WGT_W'(1 << FRAC_BITS);
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (2 * FRAC_BITS - 1));

  // operation codes
  localparam logic [OP_W-1:0] OP_STORE = 1'b0;
  localparam logic [OP_W-1:0] OP_READ  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd2;

  // reset values
  localparam logic [DIM_W-1:0] IN_HEIGHT_RST    = 7'd64;
  localparam logic [DIM_W-1:0] IN_WIDTH_RST     = 7'd64;
  localparam logic [FAC_W-1:0] SCALE_FACTOR_RST = 4'd2;

  // control word for the multiply-accumulate unit
  typedef struct packed {
    logic clear;    // load the rounding constant
    logic load_w;   // register the weight product
    logic load_p;   // register weight * sample
    logic accum;    // add the term into the sum
  } mac_ctrl_t;

endpackage
`default_nettype wire

### rtl/bu_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bu_in_if: request channel of the bilinear upsampler
// Store or read request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bu_in_if;
  logic                          valid;
  logic                          ready;
  logic [bu_pkg::OP_W-1:0]       operation;
  logic [bu_pkg::CH_W-1:0]       channel;
  logic [bu_pkg::COORD_W-1:0]    row;
  logic [bu_pkg::COORD_W-1:0]    col;
  logic [bu_pkg::SAMPLE_W-1:0]   sample_value;

  modport source (output valid, operation, channel, row, col, sample_value,
                  input ready);
  modport sink   (input valid, operation, channel, row, col, sample_value,
                  output ready);
endinterface
`default_nettype wire

### rtl/bu_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bu_out_if: result channel of the bilinear upsampler
// Interpolated pixel and range flag with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bu_out_if;
  logic                          valid;
  logic                          ready;
  logic [bu_pkg::SAMPLE_W-1:0]   interp_value;
  logic                          coord_error;

  modport source (output valid, interp_value, coord_error, input ready);
  modport sink   (input valid, interp_value, coord_error, output ready);
endinterface
`default_nettype wire

### rtl/bu_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bu_cfg_if: configuration write channel
// Register index and write data with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bu_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bu_pkg::CFG_IDX_W-1:0]    index;
  logic [bu_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/bu_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bu_div: iterative restoring divider
// Divides num * 2^FRAC_BITS by den, one quotient bit per cycle. The integer
// part is known to fit IDX_W bits, so the leading quotient bits are skipped
// and the partial remainder starts from the top of num. A zero divisor
// returns zero.
// ----------------------------------------------------------------------------
module bu_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [bu_pkg::NUM_W-1:0]   num,
  input  wire logic [bu_pkg::DEN_W-1:0]   den,
  output logic                            done,
  output logic [bu_pkg::QUOT_W-1:0]       quot
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [bu_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [bu_pkg::DEN_W-1:0]      rem_r, rem_nxt;
  logic [bu_pkg::DEN_W-1:0]      den_r, den_nxt;
  logic [bu_pkg::QUOT_W-1:0]     shin_r, shin_nxt;
  logic [bu_pkg::QUOT_W-1:0]     quot_r, quot_nxt;

  logic [bu_pkg::DEN_W:0]        trial;
  logic                          fits;

  // one trial subtraction
  assign trial = {rem_r, shin_r[bu_pkg::QUOT_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    shin_nxt = shin_r;
    quot_nxt = quot_r;
    if (start) begin
      den_nxt  = den;
      rem_nxt  = num[bu_pkg::NUM_W-1:bu_pkg::IDX_W];
      shin_nxt = {num[bu_pkg::IDX_W-1:0], {bu_pkg::FRAC_BITS{1'b0}}};
      quot_nxt = '0;
      step_nxt = '0;
      if (den == '0) begin
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt  = fits ? bu_pkg::DEN_W'(trial - {1'b0, den_r})
                      : trial[bu_pkg::DEN_W-1:0];
      shin_nxt = {shin_r[bu_pkg::QUOT_W-2:0], 1'b0};
      quot_nxt = {quot_r[bu_pkg::QUOT_W-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == bu_pkg::STEP_W'(bu_pkg::QUOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    shin_r <= shin_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

### rtl/bu_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bu_mem: sample store
// Single-port memory of all channel planes, registered read data.
// ----------------------------------------------------------------------------
module bu_mem (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [bu_pkg::ADDR_W-1:0]     addr,
  input  wire logic [bu_pkg::SAMPLE_W-1:0]   wdata,
  output logic      [bu_pkg::SAMPLE_W-1:0]   rdata
);

  logic [bu_pkg::SAMPLE_W-1:0] mem [bu_pkg::DEPTH];
  logic [bu_pkg::SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/bu_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bu_mac: shared weight multiply-accumulate unit
// Forms one corner weight, scales the sample by it and adds the term to the
// sum. Each multiply is followed by a register.
// ----------------------------------------------------------------------------
module bu_mac (
  input  wire logic                          clk,
  input  wire bu_pkg::mac_ctrl_t             ctrl,
  input  wire logic [bu_pkg::WGT_W-1:0]      wgt_a,
  input  wire logic [bu_pkg::WGT_W-1:0]      wgt_b,
  input  wire logic [bu_pkg::SAMPLE_W-1:0]   sample,
  output logic      [bu_pkg::ACC_W-1:0]      acc
);

  logic [bu_pkg::PROD_W-1:0] wprod_r;
  logic [bu_pkg::TERM_W-1:0] term_r;
  logic [bu_pkg::ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    // weight product, at most ONE * ONE
    if (ctrl.load_w) begin
      wprod_r <= bu_pkg::PROD_W'(wgt_a * wgt_b);
    end
    // weighted sample
    if (ctrl.load_p) begin
      term_r <= bu_pkg::TERM_W'(wprod_r * sample);
    end
    // sum starts at one half for rounding
    if (ctrl.clear) begin
      acc_r <= bu_pkg::ROUND_HALF;
    end else if (ctrl.accum) begin
      acc_r <= acc_r + bu_pkg::ACC_W'(term_r);
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

### rtl/bilinear_upsampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_upsampler: align-corners bilinear upsampler of a stored plane
// Holds up to four 64x64 planes of 16-bit samples. A store word writes one
// sample; a read word returns the interpolated pixel of the plane upscaled
// by scale_factor, or a range error.
//
//   channel   dir   payload
//   in_ch     in    operation, channel, row, col, sample_value
//   out_ch    out   interp_value, coord_error
//   cfg_ch    in    index, data (in_height, in_width, scale_factor)
//
// A store is written in the idle state. A read runs two 18-step
// divisions in the shared divider (row, then column) and four corners,
// each through S_CW, S_CP and S_CA of the shared multiply-accumulate unit.
// A read out of range goes straight to the output state.
// Reset is synchronous, active low; the sample store is not cleared.
// in_ch is ready only while idle; a finished result waits in the output
// register, and the next word is taken while it waits.
// ----------------------------------------------------------------------------
module bilinear_upsampler (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bu_in_if.sink      in_ch,
  bu_out_if.source   out_ch,
  bu_cfg_if.sink     cfg_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_DH0, S_DH, S_DW0, S_DW, S_CW, S_CP, S_CA, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [bu_pkg::DIM_W-1:0] in_height_r, in_width_r;
  logic [bu_pkg::FAC_W-1:0] scale_factor_r;

  // request context
  logic [bu_pkg::CH_ADDR_W-1:0] ch_r, ch_nxt;
  logic                         err_r, err_nxt;
  logic [bu_pkg::NUM_W-1:0]     num_h_r, num_h_nxt, num_w_r, num_w_nxt;
  logic [bu_pkg::DEN_W-1:0]     den_h_r, den_h_nxt, den_w_r, den_w_nxt;
  logic [bu_pkg::IDX_W-1:0]     ph_r, ph_nxt, nh_r, nh_nxt;
  logic [bu_pkg::IDX_W-1:0]     pw_r, pw_nxt, nw_r, nw_nxt;
  logic [bu_pkg::FRAC_BITS-1:0] dh_r, dh_nxt, dw_r, dw_nxt;
  logic [1:0]                   corner_r, corner_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [bu_pkg::SAMPLE_W-1:0]   out_val_r, out_val_nxt;
  logic                          out_err_r, out_err_nxt;

  // effective sizes
  logic [bu_pkg::DIM_W-1:0]  ih, iw;
  logic [bu_pkg::FAC_W-1:0]  fac;
  logic [bu_pkg::ODIM_W-1:0] oh, ow;
  logic                      in_acc, store_ok, rd_err;

  // shared units
  logic                          div_start, div_done;
  logic [bu_pkg::NUM_W-1:0]      div_num;
  logic [bu_pkg::DEN_W-1:0]      div_den;
  logic [bu_pkg::QUOT_W-1:0]     div_quot;
  logic [bu_pkg::IDX_W-1:0]      q_idx, q_next;
  logic                          mem_we;
  logic [bu_pkg::ADDR_W-1:0]     mem_addr, corner_addr;
  logic [bu_pkg::SAMPLE_W-1:0]   mem_rdata;
  bu_pkg::mac_ctrl_t             mac_ctrl;
  logic [bu_pkg::WGT_W-1:0]      wgt_h, wgt_w;
  logic [bu_pkg::ACC_W-1:0]      acc;
  logic [bu_pkg::SAMPLE_W-1:0]   acc_val;

  // clamp the register values to their legal ranges
  assign ih  = (in_height_r == '0) ? bu_pkg::DIM_W'(1) :
               (in_height_r > bu_pkg::DIM_W'(bu_pkg::MAX_HEIGHT)) ?
               bu_pkg::DIM_W'(bu_pkg::MAX_HEIGHT) : in_height_r;
  assign iw  = (in_width_r == '0) ? bu_pkg::DIM_W'(1) :
               (in_width_r > bu_pkg::DIM_W'(bu_pkg::MAX_WIDTH)) ?
               bu_pkg::DIM_W'(bu_pkg::MAX_WIDTH) : in_width_r;
  assign fac = (scale_factor_r == '0) ? bu_pkg::FAC_W'(1) :
               (scale_factor_r > bu_pkg::FAC_W'(bu_pkg::MAX_FACTOR)) ?
               bu_pkg::FAC_W'(bu_pkg::MAX_FACTOR) : scale_factor_r;
  assign oh  = bu_pkg::ODIM_W'(ih * fac);
  assign ow  = bu_pkg::ODIM_W'(iw * fac);

  // request checks
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign store_ok = (32'(in_ch.channel) < bu_pkg::MAX_CHANNELS) &&
                    ({2'b00, in_ch.row} < bu_pkg::COORD_W'(0) + 11'(ih)) &&
                    ({2'b00, in_ch.col} < 11'(iw));
  assign rd_err   = (32'(in_ch.channel) >= bu_pkg::MAX_CHANNELS) ||
                    ({1'b0, in_ch.row} >= oh) || ({1'b0, in_ch.col} >= ow);

  // divider operands follow the axis being mapped
  assign div_num = (state_r == S_DW0) ? num_w_r : num_h_r;
  assign div_den = (state_r == S_DW0) ? den_w_r : den_h_r;
  assign q_idx   = div_quot[bu_pkg::QUOT_W-1:bu_pkg::FRAC_BITS];

  // next index, clamped at the last row or column of the axis
  always_comb begin
    if (state_r == S_DW) begin
      q_next = ((7'(q_idx) + 7'd1) >= iw) ? q_idx : q_idx + 1'b1;
    end else begin
      q_next = ((7'(q_idx) + 7'd1) >= ih) ? q_idx : q_idx + 1'b1;
    end
  end

  // corner select: bit 1 picks the row, bit 0 the column
  assign corner_addr = {ch_r, corner_r[1] ? nh_r : ph_r, corner_r[0] ? nw_r : pw_r};
  assign wgt_h = corner_r[1] ? {1'b0, dh_r} : bu_pkg::ONE - {1'b0, dh_r};
  assign wgt_w = corner_r[0] ? {1'b0, dw_r} : bu_pkg::ONE - {1'b0, dw_r};

  // rounded sum, saturated
  assign acc_val = (|acc[bu_pkg::ACC_W-1:2*bu_pkg::FRAC_BITS+bu_pkg::SAMPLE_W]) ?
                   '1 : acc[2*bu_pkg::FRAC_BITS+bu_pkg::SAMPLE_W-1:2*bu_pkg::FRAC_BITS];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    err_nxt       = err_r;
    num_h_nxt     = num_h_r;
    num_w_nxt     = num_w_r;
    den_h_nxt     = den_h_r;
    den_w_nxt     = den_w_r;
    ph_nxt        = ph_r;
    nh_nxt        = nh_r;
    pw_nxt        = pw_r;
    nw_nxt        = nw_r;
    dh_nxt        = dh_r;
    dw_nxt        = dw_r;
    corner_nxt    = corner_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_val_nxt   = out_val_r;
    out_err_nxt   = out_err_r;
    mem_we        = 1'b0;
    mem_addr      = corner_addr;
    div_start     = 1'b0;
    mac_ctrl      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ch_nxt = in_ch.channel[bu_pkg::CH_ADDR_W-1:0];
          if (in_ch.operation == bu_pkg::OP_STORE) begin
            mem_we   = store_ok;
            mem_addr = {in_ch.channel[bu_pkg::CH_ADDR_W-1:0],
                        in_ch.row[bu_pkg::IDX_W-1:0], in_ch.col[bu_pkg::IDX_W-1:0]};
          end else if (rd_err) begin
            err_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else begin
            err_nxt   = 1'b0;
            num_h_nxt = bu_pkg::NUM_W'((ih - 1'b1) * in_ch.row);
            num_w_nxt = bu_pkg::NUM_W'((iw - 1'b1) * in_ch.col);
            den_h_nxt = bu_pkg::DEN_W'(oh - 1'b1);
            den_w_nxt = bu_pkg::DEN_W'(ow - 1'b1);
            state_nxt = S_DH0;
          end
        end
      end
      S_DH0: begin
        div_start      = 1'b1;
        mac_ctrl.clear = 1'b1;
        state_nxt      = S_DH;
      end
      S_DH: begin
        if (div_done) begin
          ph_nxt    = q_idx;
          nh_nxt    = q_next;
          dh_nxt    = div_quot[bu_pkg::FRAC_BITS-1:0];
          state_nxt = S_DW0;
        end
      end
      S_DW0: begin
        div_start = 1'b1;
        state_nxt = S_DW;
      end
      S_DW: begin
        if (div_done) begin
          pw_nxt     = q_idx;
          nw_nxt     = q_next;
          dw_nxt     = div_quot[bu_pkg::FRAC_BITS-1:0];
          corner_nxt = 2'd0;
          state_nxt  = S_CW;
        end
      end
      // read the corner sample while the weight product forms
      S_CW: begin
        mac_ctrl.load_w = 1'b1;
        state_nxt       = S_CP;
      end
      S_CP: begin
        mac_ctrl.load_p = 1'b1;
        state_nxt       = S_CA;
      end
      S_CA: begin
        mac_ctrl.accum = 1'b1;
        corner_nxt     = corner_r + 1'b1;
        state_nxt      = (corner_r == 2'd3) ? S_OUT : S_CW;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = err_r ? '0 : acc_val;
          out_err_nxt   = err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      in_height_r    <= bu_pkg::IN_HEIGHT_RST;
      in_width_r     <= bu_pkg::IN_WIDTH_RST;
      scale_factor_r <= bu_pkg::SCALE_FACTOR_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      // configuration writes
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          bu_pkg::REG_IN_HEIGHT:    in_height_r    <= cfg_ch.data;
          bu_pkg::REG_IN_WIDTH:     in_width_r     <= cfg_ch.data;
          bu_pkg::REG_SCALE_FACTOR: scale_factor_r <= cfg_ch.data[bu_pkg::FAC_W-1:0];
          default: ;
        endcase
      end
    end
    ch_r     <= ch_nxt;
    err_r    <= err_nxt;
    num_h_r  <= num_h_nxt;
    num_w_r  <= num_w_nxt;
    den_h_r  <= den_h_nxt;
    den_w_r  <= den_w_nxt;
    ph_r     <= ph_nxt;
    nh_r     <= nh_nxt;
    pw_r     <= pw_nxt;
    nw_r     <= nw_nxt;
    dh_r     <= dh_nxt;
    dw_r     <= dw_nxt;
    corner_r <= corner_nxt;
    out_val_r <= out_val_nxt;
    out_err_r <= out_err_nxt;
  end

  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.interp_value = out_val_r;
  assign out_ch.coord_error  = out_err_r;

  bu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  bu_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_ch.sample_value),
    .rdata (mem_rdata)
  );

  bu_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .wgt_a  (wgt_h),
    .wgt_b  (wgt_w),
    .sample (mem_rdata),
    .acc    (acc)
  );

`ifndef NO_ASSERTIONS
  // the divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DH || state_r == S_DW))
    else $error("divider done outside a wait state");

  // an error result carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_val_r == '0))
    else $error("error result with nonzero value");

  // a read in range starts the row division next
  a_read_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.operation == bu_pkg::OP_READ && !rd_err) |=> (state_r == S_DH0))
    else $error("read in range did not start the division");

  // the corner sequence starts at the first corner
  a_corner_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DW && div_done) |=> (state_r == S_CW && corner_r == 2'd0))
    else $error("corner sequence did not start at the first corner");
`endif

endmodule
`default_nettype wire

### verif/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the bilinear upsampler
// A directed run at the reset sizes, then random phases under several plane
// sizes, the extremes and out-of-range register values among them. Each
// read is checked field by field against a fixed directed expectation or
// an in-bench align-corners interpolator; reads touch only stored samples.
// ----------------------------------------------------------------------------
module testbench;
  import bu_pkg::*;

  localparam int NUM_DIRECTED    = 25;
  localparam int NUM_PHASES      = 9;
  localparam int WORDS_PER_PHASE = 75;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 16;
  localparam int DRAIN_CYCLES    = 64;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                err;
  } pixel_result_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [CH_W-1:0]     ch;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [SAMPLE_W-1:0] sample_v;
    logic                typed;
    pixel_result_t       want;
  } directed_word_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] rows;
    logic [CFG_DATA_W-1:0] cols;
    logic [CFG_DATA_W-1:0] factor;
  } plane_cfg_t;

  localparam pixel_result_t NO_RESULT   = '0;
  localparam pixel_result_t RANGE_ERROR = '{value: '0, err: 1'b1};

  // directed words, run at the reset sizes (64 x 64, factor 2: output 128 x 128)
  localparam directed_word_t DIRECTED_WORDS [NUM_DIRECTED] = '{
    '{OP_STORE, 2'd0,   9'd0,   9'd0, 16'hFFFF, 1'b0, NO_RESULT},
    '{OP_STORE, 2'd0,   9'd0,   9'd1, 16'h0000, 1'b0, NO_RESULT},
    '{OP_STORE, 2'd0,   9'd1,   9'd0, 16'h0000, 1'b0, NO_RESULT},
    '{OP_STORE, 2'd0,   9'd1,   9'd1, 16'hFFFF, 1'b0, NO_RESULT},
    '{OP_STORE, 2'd3,  9'd63,  9'd63, 16'hA5A5, 1'b0, NO_RESULT},
    // stores outside the plane are dropped
    '{OP_STORE, 2'd2,  9'd64,   9'd0, 16'h1111, 1'b0, NO_RESULT},
    '{OP_STORE, 2'd2,   9'd0,  9'd64, 16'h2222, 1'b0, NO_RESULT},
    '{OP_STORE, 2'd1, 9'd511, 9'd511, 16'h3333, 1'b0, NO_RESULT},
    // first and last output pixels sit exactly on input samples, then reads between samples
    '{OP_READ,  2'd0,   9'd0,   9'd0, 16'hFFFF, 1'b1, '{16'hFFFF, 1'b0}},
    '{OP_READ,  2'd3, 9'd127, 9'd127, 16'h0000, 1'b1, '{16'hA5A5, 1'b0}},
    '{OP_READ,  2'd0,   9'd0,   9'd1, 16'h5A5A, 1'b0, NO_RESULT},
    '{OP_READ,  2'd0,   9'd1,   9'd1, 16'h0000, 1'b0, NO_RESULT},
    '{OP_READ,  2'd0,   9'd1,   9'd0, 16'hFFFF, 1'b0, NO_RESULT},
    // reads past the output size
    '{OP_READ,  2'd0, 9'd128,   9'd0, 16'h0000, 1'b1, RANGE_ERROR},
    '{OP_READ,  2'd0,   9'd0, 9'd128, 16'hFFFF, 1'b1, RANGE_ERROR},
    '{OP_READ,  2'd3, 9'd511, 9'd511, 16'hFFFF, 1'b1, RANGE_ERROR},
    '{OP_READ,  2'd1, 9'd256, 9'd300, 16'h0000, 1'b1, RANGE_ERROR},
    // overwrite keeps the latest sample
    '{OP_STORE, 2'd0,   9'd0,   9'd0, 16'h0000, 1'b0, NO_RESULT},
    '{OP_READ,  2'd0,   9'd0,   9'd0, 16'h0000, 1'b1, '{16'h0000, 1'b0}},
    // corners near mid-scale exercise rounding
    '{OP_STORE, 2'd1,   9'd0,   9'd0, 16'h8000, 1'b0, NO_RESULT},
    '{OP_STORE, 2'd1,   9'd0,   9'd1, 16'h8001, 1'b0, NO_RESULT},
    '{OP_STORE, 2'd1,   9'd1,   9'd0, 16'h7FFF, 1'b0, NO_RESULT},
    '{OP_STORE, 2'd1,   9'd1,   9'd1, 16'hFFFF, 1'b0, NO_RESULT},
    '{OP_READ,  2'd1,   9'd1,   9'd1, 16'h0000, 1'b0, NO_RESULT},
    '{OP_READ,  2'd1,   9'd2,   9'd2, 16'hFFFF, 1'b0, NO_RESULT}
  };

  // plane sizes per random phase: raw register values, zero and oversize included
  localparam plane_cfg_t PHASE_CFG [NUM_PHASES] = '{
    '{7'd64,  7'd64,  7'd8},
    '{7'd1,   7'd1,   7'd1},
    '{7'd0,   7'd0,   7'd0},
    '{7'd127, 7'd127, 7'd15},
    '{7'd3,   7'd5,   7'd3},
    '{7'd1,   7'd64,  7'd8},
    '{7'd64,  7'd1,   7'd1},
    '{7'd7,   7'd2,   7'd5},
    '{7'd2,   7'd2,   7'd4}
  };

  logic clk;
  logic rst_n;

  bu_in_if  in_if ();
  bu_out_if out_if ();
  bu_cfg_if cfg_if ();

  bilinear_upsampler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // shadow of the block's registers and sample store
  logic [DIM_W-1:0]    shadow_rows;
  logic [DIM_W-1:0]    shadow_cols;
  logic [FAC_W-1:0]    shadow_factor;
  logic [SAMPLE_W-1:0] sample_mem [DEPTH];
  bit                  sample_written [DEPTH];

  pixel_result_t pending_pixels [$];
  int          mismatches;
  int          phase_words;
  int unsigned tx_calm;
  int unsigned rx_calm;
  int unsigned rx_stall;
  bit          pressure_go;
  logic        hold_off;

  // clock and reset
  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // run limit
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned eff_size(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int unsigned plane_rows();
    return eff_size(shadow_rows, MAX_HEIGHT);
  endfunction

  function automatic int unsigned plane_cols();
    return eff_size(shadow_cols, MAX_WIDTH);
  endfunction

  function automatic int unsigned plane_factor();
    return eff_size(shadow_factor, MAX_FACTOR);
  endfunction

  function automatic int unsigned sample_addr(int unsigned ch, int unsigned r, int unsigned c);
    return (ch * MAX_HEIGHT + r) * MAX_WIDTH + c;
  endfunction

  // align-corners source position of output coordinate o on an axis of n inputs
  function automatic void map_axis(input int unsigned o, input int unsigned n,
                                   input int unsigned m, output int unsigned prev,
                                   output int unsigned next, output int unsigned frac);
    longint unsigned num;
    longint unsigned den;
    prev = 0;
    frac = 0;
    if (m > 1) begin
      num  = longint'(n - 1) * o;
      den  = m - 1;
      prev = num / den;
      frac = ((num % den) << FRAC_BITS) / den;
    end
    if (prev > n - 1) prev = n - 1;
    next = (prev + 1 >= n) ? prev : prev + 1;
  endfunction

  function automatic pixel_result_t bilinear_pixel(logic [CH_W-1:0] ch,
                                                   logic [COORD_W-1:0] r,
                                                   logic [COORD_W-1:0] c);
    int unsigned     ih, iw, oh, ow, ph, nh, pw, nw, dh, dw;
    longint unsigned one, acc;
    pixel_result_t   res;
    ih = plane_rows();
    iw = plane_cols();
    oh = ih * plane_factor();
    ow = iw * plane_factor();
    res = RANGE_ERROR;
    if (ch >= MAX_CHANNELS || r >= oh || c >= ow) return res;
    map_axis(r, ih, oh, ph, nh, dh);
    map_axis(c, iw, ow, pw, nw, dw);
    one = 64'd1 << FRAC_BITS;
    acc = (one - dh) * (one - dw) * sample_mem[sample_addr(ch, ph, pw)]
        + (one - dh) * dw * sample_mem[sample_addr(ch, ph, nw)]
        + dh * (one - dw) * sample_mem[sample_addr(ch, nh, pw)]
        + longint'(dh) * dw * sample_mem[sample_addr(ch, nh, nw)];
    acc = (acc + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
    if (acc > 64'hFFFF) acc = 64'hFFFF;
    res.value = acc[SAMPLE_W-1:0];
    res.err   = 1'b0;
    return res;
  endfunction

  function automatic bit store_lands(logic [CH_W-1:0] ch, logic [COORD_W-1:0] r,
                                     logic [COORD_W-1:0] c);
    return ch < MAX_CHANNELS && r < plane_rows() && c < plane_cols();
  endfunction

  // ------------------------------------------------------------- random helpers

  // mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  // coordinate below n, biased toward both ends of the axis
  function automatic logic [COORD_W-1:0] pick_coord(int unsigned n);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 3) return '0;
    if (roll < 6) return COORD_W'(n - 1);
    return COORD_W'($urandom_range(0, n - 1));
  endfunction

  // -------------------------------------------------------------------- driving

  initial begin
    in_if.valid        = 1'b0;
    in_if.operation    = OP_STORE;
    in_if.channel      = '0;
    in_if.row          = '0;
    in_if.col          = '0;
    in_if.sample_value = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_IN_HEIGHT;
    cfg_if.data        = '0;
    out_if.ready       = 1'b0;
    hold_off           = 1'b0;
  end

  // one input word: optional gap, hold until taken, then expect a result or update the shadow
  task automatic send_word(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                           input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                           input logic [SAMPLE_W-1:0] v, input bit typed,
                           input pixel_result_t want);
    int unsigned gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.operation    <= op;
    in_if.channel      <= ch;
    in_if.row          <= r;
    in_if.col          <= c;
    in_if.sample_value <= v;
    do @(posedge clk); while (!in_if.ready);
    if (op == OP_READ) begin
      pending_pixels.push_back(typed ? want : bilinear_pixel(ch, r, c));
      phase_words++;
    end else if (store_lands(ch, r, c)) begin
      sample_mem[sample_addr(ch, r, c)]     = v;
      sample_written[sample_addr(ch, r, c)] = 1'b1;
      phase_words++;
    end
  endtask

  // wait for every result, then let a trailing store finish
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_plane(input plane_cfg_t pc);
    logic [CFG_IDX_W-1:0]  idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    idx = '{REG_IN_HEIGHT, REG_IN_WIDTH, REG_SCALE_FACTOR};
    val = '{pc.rows, pc.cols, pc.factor};
    cfg_if.valid <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      cfg_if.index <= idx[k];
      cfg_if.data  <= val[k];
      do @(posedge clk); while (!cfg_if.ready);
      case (idx[k])
        REG_IN_HEIGHT:    shadow_rows   = val[k][DIM_W-1:0];
        REG_IN_WIDTH:     shadow_cols   = val[k][DIM_W-1:0];
        REG_SCALE_FACTOR: shadow_factor = val[k][FAC_W-1:0];
        default: ;
      endcase
    end
    cfg_if.valid <= 1'b0;
  endtask

  // store any corner of a read that has never been written
  task automatic fill_corners(input logic [CH_W-1:0] ch, input logic [COORD_W-1:0] r,
                              input logic [COORD_W-1:0] c);
    int unsigned ih, iw, ph, nh, pw, nw, dh, dw, rr, cc;
    ih = plane_rows();
    iw = plane_cols();
    map_axis(r, ih, ih * plane_factor(), ph, nh, dh);
    map_axis(c, iw, iw * plane_factor(), pw, nw, dw);
    for (int k = 0; k < 4; k++) begin
      rr = (k >= 2) ? nh : ph;
      cc = (k % 2 == 1) ? nw : pw;
      if (!sample_written[sample_addr(ch, rr, cc)])
        send_word(OP_STORE, ch, COORD_W'(rr), COORD_W'(cc), pick_sample(), 1'b0, NO_RESULT);
    end
  endtask

  // one random word: mostly legal reads with their corners in place
  task automatic random_word();
    int unsigned     roll, ih, iw, oh, ow;
    logic [CH_W-1:0] ch;
    logic [COORD_W-1:0] r, c;
    ih   = plane_rows();
    iw   = plane_cols();
    oh   = ih * plane_factor();
    ow   = iw * plane_factor();
    roll = $urandom_range(0, 99);
    ch   = $urandom_range(0, MAX_CHANNELS - 1);
    if (roll < 12) begin
      r = $urandom_range(0, ih - 1);
      c = $urandom_range(0, iw - 1);
      send_word(OP_STORE, ch, r, c, pick_sample(), 1'b0, NO_RESULT);
    end else if (roll < 20 && (oh < 512 || ow < 512)) begin
      // read past the output plane
      r = pick_coord(oh);
      c = pick_coord(ow);
      if (ow >= 512 || (oh < 512 && $urandom_range(0, 1) == 1))
        r = $urandom_range(oh, 511);
      else
        c = $urandom_range(ow, 511);
      send_word(OP_READ, ch, r, c, pick_sample(), 1'b0, NO_RESULT);
    end else if (roll < 26) begin
      // store outside the input plane, dropped by the block
      r = $urandom_range(0, 511);
      c = $urandom_range(0, 511);
      if ($urandom_range(0, 1) == 1) r = $urandom_range(ih, 511);
      else c = $urandom_range(iw, 511);
      send_word(OP_STORE, ch, r, c, pick_sample(), 1'b0, NO_RESULT);
    end else begin
      r = pick_coord(oh);
      c = pick_coord(ow);
      fill_corners(ch, r, c);
      send_word(OP_READ, ch, r, c, pick_sample(), 1'b0, NO_RESULT);
    end
  endtask

  // input side: directed words, random phases, then drain
  initial begin
    directed_word_t dw;
    mismatches    = 0;
    tx_calm       = 0;
    pressure_go   = 1'b0;
    shadow_rows   = IN_HEIGHT_RST;
    shadow_cols   = IN_WIDTH_RST;
    shadow_factor = SCALE_FACTOR_RST;
    wait (rst_n);
    @(posedge clk);
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      dw = DIRECTED_WORDS[i];
      send_word(dw.op, dw.ch, dw.row, dw.col, dw.sample_v, dw.typed, dw.want);
    end
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_plane(PHASE_CFG[p]);
      if (p == 0) pressure_go = 1'b1;
      phase_words = 0;
      while (phase_words < WORDS_PER_PHASE) random_word();
    end
    in_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ------------------------------------------------------------ result checking

  initial begin
    rx_calm  = 0;
    rx_stall = 0;
  end

  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result word: interp_value %h coord_error %b",
               out_if.interp_value, out_if.coord_error);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_if.interp_value !== want.value) begin
          $error("interp_value: expected %h, actual %h", want.value, out_if.interp_value);
          mismatches++;
        end
        if (out_if.coord_error !== want.err) begin
          $error("coord_error: expected %b, actual %b", want.err, out_if.coord_error);
          mismatches++;
        end
      end
    end
    // ready with random stalls
    if (!rst_n || hold_off) begin
      out_if.ready <= 1'b0;
    end else if (rx_stall > 0) begin
      out_if.ready <= 1'b0;
      rx_stall--;
    end else begin
      out_if.ready <= 1'b1;
      rx_stall = pick_gap(rx_calm);
    end
  end

endmodule
`default_nettype wire
